/* rtl/core/peak_live_waste_tracker_defines.svh */
// ----------------------------------------------------------------------------
// peak_live_waste_tracker assertion macros
// Shared concurrent assertion forms for the waste tracker RTL.
// ----------------------------------------------------------------------------
`ifndef PEAK_LIVE_WASTE_TRACKER_DEFINES_SVH
`define PEAK_LIVE_WASTE_TRACKER_DEFINES_SVH

// check a consequent in the same cycle as its antecedent
`define PLWT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plwt same-cycle check failed");

// check a consequent in the cycle after its antecedent
`define PLWT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plwt next-cycle check failed");

`endif

/* rtl/core/plwt_pkg.sv */
// ----------------------------------------------------------------------------
// plwt_pkg
// Types and constants shared by the waste tracker core and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plwt_pkg;

  localparam int TIME_W  = 48;
  localparam int BYTES_W = 32;
  localparam int SUM_W   = 38;

  typedef struct packed {
    logic               clear_first;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  end_time;
    logic [BYTES_W-1:0] alloc_size;
    logic [BYTES_W-1:0] access_low;
    logic [BYTES_W-1:0] access_high;
  } plwt_in_t;

  typedef struct packed {
    logic [SUM_W-1:0] running_waste;
    logic [SUM_W-1:0] max_waste;
    logic             skipped;
    logic             overflow;
  } plwt_out_t;

  typedef struct packed {
    logic               valid;
    logic [TIME_W-1:0]  end_time;
    logic [BYTES_W-1:0] waste;
  } plwt_entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_POP,
    OP_INSERT
  } plwt_op_t;

  typedef struct packed {
    plwt_op_t           op;
    logic [TIME_W-1:0]  key;
    logic [BYTES_W-1:0] waste;
  } plwt_ctl_t;

endpackage

/* rtl/core/peak_live_waste_tracker.sv */
// ----------------------------------------------------------------------------
// peak_live_waste_tracker
// Peak concurrent waste over live allocations, kept in a sorted cell chain.
//
//   channel   ports                     handshake
//   input     start, busy, in_data      beat taken when start && !busy
//   result    out_valid, out_data       one-cycle strobe, never stalled
//
// A beat first retires expired entries from the chain head, one per cycle,
// then inserts the new entry (unless skipped or the chain is full) in the
// cycle in which the result is registered.
// Reset (rst_n low, synchronous) empties the chain and zeroes the sums.
// busy is high from the cycle after acceptance until the result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "peak_live_waste_tracker_defines.svh"

module peak_live_waste_tracker #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  plwt_pkg::plwt_in_t  in_data,
  output logic                out_valid,
  output plwt_pkg::plwt_out_t out_data
);
  import plwt_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_t;

  state_t             state_r, state_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;
  logic [TIME_W-1:0]  end_r, end_nxt;
  logic [BYTES_W-1:0] waste_r, waste_nxt;
  logic               skip_r, skip_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W-1:0]   peak_r, peak_nxt;
  logic               out_valid_r, out_valid_nxt;
  plwt_out_t          out_data_r, out_data_nxt;

  plwt_ctl_t            ctl;
  plwt_entry_t          ent [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] ins;
  logic [STORE_DEPTH-1:0] vld;

  logic               accept;
  logic               pop_now;
  logic               full;
  logic [BYTES_W-1:0] span;
  logic [SUM_W-1:0]   sum_add;

  assign busy      = (state_r == ST_WORK);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign accept  = start && (state_r == ST_IDLE);
  assign pop_now = (state_r == ST_WORK) && ent[0].valid && (ent[0].end_time < start_r);
  assign full    = ent[STORE_DEPTH-1].valid;
  assign span    = in_data.access_high - in_data.access_low;
  assign sum_add = sum_r + {{(SUM_W-BYTES_W){1'b0}}, waste_r};

  always_comb begin
    ctl.key   = end_r;
    ctl.waste = waste_r;
    if (accept && in_data.clear_first) begin
      ctl.op = OP_CLEAR;
    end else if (pop_now) begin
      ctl.op = OP_POP;
    end else if ((state_r == ST_WORK) && !skip_r && !full) begin
      ctl.op = OP_INSERT;
    end else begin
      ctl.op = OP_HOLD;
    end
  end

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    plwt_entry_t prev_e;
    plwt_entry_t next_e;
    logic        prev_i;

    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_i = 1'b0;
    end else begin : g_body
      assign prev_e = ent[i-1];
      assign prev_i = ins[i-1];
    end

    if (i == STORE_DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_link
      assign next_e = ent[i+1];
    end

    plwt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .prev_ins (prev_i),
      .prev_ent (prev_e),
      .next_ent (next_e),
      .ent_o    (ent[i]),
      .ins_o    (ins[i])
    );

    assign vld[i] = ent[i].valid;
  end

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    waste_nxt     = waste_r;
    skip_nxt      = skip_r;
    sum_nxt       = sum_r;
    peak_nxt      = peak_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          start_nxt = in_data.start_time;
          end_nxt   = in_data.end_time;
          skip_nxt  = span > in_data.alloc_size;
          waste_nxt = in_data.alloc_size - span;
          if (in_data.clear_first) begin
            sum_nxt  = '0;
            peak_nxt = '0;
          end
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        if (pop_now) begin
          sum_nxt = sum_r - {{(SUM_W-BYTES_W){1'b0}}, ent[0].waste};
        end else begin
          out_data_nxt.skipped  = skip_r;
          out_data_nxt.overflow = !skip_r && full;
          if (!skip_r && !full) begin
            sum_nxt  = sum_add;
            peak_nxt = (sum_add > peak_r) ? sum_add : peak_r;
          end
          out_data_nxt.running_waste = sum_nxt;
          out_data_nxt.max_waste     = peak_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    waste_r    <= waste_nxt;
    skip_r     <= skip_nxt;
    out_data_r <= out_data_nxt;
  end

  `PLWT_ASSERT_SAME(a_chain_packed, clk, rst_n, 1'b1, ((vld >> 1) & ~vld) == '0)
  `PLWT_ASSERT_NEXT(a_pop_stays_busy, clk, rst_n, pop_now, busy && !out_valid)
  `PLWT_ASSERT_NEXT(a_finish_strobes, clk, rst_n, busy && !pop_now, out_valid && !busy)
  `PLWT_ASSERT_NEXT(a_pop_subtracts, clk, rst_n, pop_now,
                    sum_r == $past(sum_r - {{(SUM_W-BYTES_W){1'b0}}, ent[0].waste}))
  `PLWT_ASSERT_SAME(a_one_flag, clk, rst_n, out_valid,
                    !(out_data.skipped && out_data.overflow))

endmodule

/* rtl/core/plwt_cell.sv */
// ----------------------------------------------------------------------------
// plwt_cell
// One slot of the sorted live-entry chain, ordered by ascending end time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plwt_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  plwt_pkg::plwt_ctl_t  ctl,
  input  logic                 prev_ins,
  input  plwt_pkg::plwt_entry_t prev_ent,
  input  plwt_pkg::plwt_entry_t next_ent,
  output plwt_pkg::plwt_entry_t ent_o,
  output logic                 ins_o
);
  import plwt_pkg::*;

  plwt_entry_t ent_r;
  plwt_entry_t ent_nxt;

  assign ent_o = ent_r;
  assign ins_o = !ent_r.valid || (ctl.key < ent_r.end_time);

  always_comb begin
    ent_nxt = ent_r;
    unique case (ctl.op)
      OP_HOLD:  ent_nxt = ent_r;
      OP_CLEAR: ent_nxt.valid = 1'b0;
      OP_POP:   ent_nxt = next_ent;
      OP_INSERT: begin
        if (prev_ins) begin
          ent_nxt = prev_ent;
        end else if (ins_o) begin
          ent_nxt.valid    = 1'b1;
          ent_nxt.end_time = ctl.key;
          ent_nxt.waste    = ctl.waste;
        end
      end
      default:  ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

/* tb/tb_peak_live_waste_tracker.sv */
// ----------------------------------------------------------------------------
// tb_peak_live_waste_tracker
// Drives allocation records into the waste tracker and checks every result
// beat against a local sweep-line tracker of live waste. Directed tests cover
// field extremes, span wrap, expiry boundaries, clears and a full store;
// random traffic follows, as random records and timed bursts with random gaps on the input side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_peak_live_waste_tracker;
  import plwt_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int RANDOM_RECORDS = 800;
  localparam int BEAT_LATENCY = STORE_DEPTH + 8;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  plwt_in_t  in_data;
  logic      out_valid;
  plwt_out_t out_data;

  logic [TIME_W-1:0]  live_end [STORE_DEPTH];
  logic [BYTES_W-1:0] live_bytes [STORE_DEPTH];
  int                 live_n;
  logic [SUM_W-1:0]   sum_waste;
  logic [SUM_W-1:0]   peak_sum;

  plwt_out_t expected_sums[$];
  plwt_out_t due_sum;
  int        fault_count;
  int        sent_count;
  bit        steady;

  peak_live_waste_tracker #(.STORE_DEPTH(STORE_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic plwt_out_t track_record(plwt_in_t rec);
    plwt_out_t          res;
    logic [BYTES_W-1:0] span;
    int                 idx;
    res = '0;
    if (rec.clear_first) begin
      live_n = 0;
      sum_waste = '0;
      peak_sum = '0;
    end
    idx = 0;
    while (idx < live_n) begin
      if (live_end[idx] < rec.start_time) begin
        sum_waste = sum_waste - live_bytes[idx];
        live_n--;
        live_end[idx] = live_end[live_n];
        live_bytes[idx] = live_bytes[live_n];
      end else begin
        idx++;
      end
    end
    span = rec.access_high - rec.access_low;
    if (span > rec.alloc_size) begin
      res.skipped = 1'b1;
    end else if (live_n >= STORE_DEPTH) begin
      res.overflow = 1'b1;
    end else begin
      live_end[live_n] = rec.end_time;
      live_bytes[live_n] = rec.alloc_size - span;
      live_n++;
      sum_waste = sum_waste + (rec.alloc_size - span);
      if (sum_waste > peak_sum) peak_sum = sum_waste;
    end
    res.running_waste = sum_waste;
    res.max_waste = peak_sum;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_record(input logic clr, input logic [TIME_W-1:0] st,
                             input logic [TIME_W-1:0] en, input logic [BYTES_W-1:0] sz,
                             input logic [BYTES_W-1:0] lo, input logic [BYTES_W-1:0] hi);
    plwt_in_t rec;
    int       gap;
    rec.clear_first = clr;
    rec.start_time  = st;
    rec.end_time    = en;
    rec.alloc_size  = sz;
    rec.access_low  = lo;
    rec.access_high = hi;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= rec;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_sums.push_back(track_record(rec));
    sent_count++;
  endtask

  // mostly fitting spans, a few random ones that usually skip
  task automatic send_timed(input logic clr, input logic [TIME_W-1:0] st,
                            input logic [TIME_W-1:0] en);
    logic [BYTES_W-1:0] sz;
    logic [BYTES_W-1:0] lo;
    logic [BYTES_W-1:0] span;
    sz = ($urandom_range(0, 3) == 0) ? BYTES_W'($urandom_range(0, 256)) : BYTES_W'($urandom);
    lo = $urandom;
    if ($urandom_range(0, 6) == 0) begin
      send_record(clr, st, en, sz, lo, $urandom);
    end else begin
      span = $urandom_range(0, sz);
      send_record(clr, st, en, sz, lo, lo + span);
    end
  endtask

  task automatic test_field_extremes();
    send_record(1'b1, '0, '0, BYTES_MAX, '0, '0);
    send_record(1'b0, '0, TIME_MAX, BYTES_MAX, BYTES_MAX, BYTES_MAX);
    send_record(1'b0, 48'd1, 48'd9, 32'd0, 32'd5, 32'd5);
    send_record(1'b0, 48'd2, 48'd20, 32'd100, 32'd10, 32'd110);
    send_record(1'b0, 48'd3, 48'd20, 32'd100, 32'd10, 32'd111);
    send_record(1'b0, 48'd4, 48'd20, 32'd1000, 32'd200, 32'd100);
    send_record(1'b0, 48'd5, 48'd30, BYTES_MAX, 32'd1, 32'd0);
    send_record(1'b0, TIME_MAX, TIME_MAX, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
  endtask

  task automatic test_expiry_boundary();
    send_record(1'b1, 48'd50, 48'd100, 32'd4000, 32'd0, 32'd1000);
    send_record(1'b0, 48'd60, 48'd200, 32'd700, 32'd100, 32'd200);
    send_record(1'b0, 48'd100, 48'd300, 32'd50, 32'd0, 32'd10);
    send_record(1'b0, 48'd101, 48'd300, 32'd90, 32'd0, 32'd80);
    send_record(1'b0, 48'd20, 48'd400, 32'd10, 32'd0, 32'd1);
    send_record(1'b0, 48'd301, 48'd500, 32'd5, 32'd0, 32'd1);
    send_record(1'b1, 48'd302, 48'd600, 32'd8, 32'd2, 32'd4);
  endtask

  task automatic test_store_full();
    int k;
    steady = 1'b1;
    send_record(1'b1, 48'd1000, 48'd5000, 32'd1000 + $urandom_range(0, 999), '0, '0);
    for (k = 1; k < STORE_DEPTH; k++)
      send_record(1'b0, 48'd1000 + k, 48'd5000, BYTES_W'($urandom), '0, '0);
    send_record(1'b0, 48'd2000, 48'd6000, 32'd77, 32'd0, 32'd7);
    send_record(1'b0, 48'd2001, 48'd6000, 32'd10, 32'd0, 32'd11);
    send_record(1'b0, 48'd5001, 48'd7000, 32'd33, 32'd3, 32'd30);
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int                first;
    int                kind;
    int                len;
    int                k;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] dur;
    first = sent_count;
    t = TIME_W'({$urandom, $urandom});
    while (sent_count - first < RANDOM_RECORDS) begin
      kind = $urandom_range(0, 9);
      steady = ($urandom_range(0, 3) == 0);
      if (kind == 0) begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++)
          send_record($urandom_range(0, 7) == 0, TIME_W'({$urandom, $urandom}),
                      TIME_W'({$urandom, $urandom}), $urandom, $urandom, $urandom);
      end else if (kind == 1) begin
        len = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 10);
        t = TIME_W'({$urandom, $urandom});
        for (k = 0; k < len; k++) begin
          t = t + $urandom_range(0, 3);
          send_timed(k == 0, t, t + 48'h1_0000_0000);
        end
      end else begin
        len = $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) t = TIME_W'({$urandom, $urandom});
        for (k = 0; k < len; k++) begin
          t = t + $urandom_range(0, 20);
          dur = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom_range(0, 100000))
                                            : TIME_W'($urandom_range(0, 60));
          send_timed(k == 0 && $urandom_range(0, 3) == 0, t, t + dur);
        end
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_sums.size() == 0) begin
        $error("result beat with no record outstanding");
        fault_count++;
      end else begin
        due_sum = expected_sums.pop_front();
        if (out_data.running_waste !== due_sum.running_waste) begin
          $error("running_waste: expected %0d, got %0d", due_sum.running_waste,
                 out_data.running_waste);
          fault_count++;
        end
        if (out_data.max_waste !== due_sum.max_waste) begin
          $error("max_waste: expected %0d, got %0d", due_sum.max_waste,
                 out_data.max_waste);
          fault_count++;
        end
        if (out_data.skipped !== due_sum.skipped) begin
          $error("skipped: expected %0b, got %0b", due_sum.skipped, out_data.skipped);
          fault_count++;
        end
        if (out_data.overflow !== due_sum.overflow) begin
          $error("overflow: expected %0b, got %0b", due_sum.overflow, out_data.overflow);
          fault_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("peak_live_waste_tracker test failed");
    $finish;
  end

  initial begin
    int waited;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    live_n = 0;
    sum_waste = '0;
    peak_sum = '0;
    fault_count = 0;
    sent_count = 0;
    steady = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_expiry_boundary();
    test_store_full();
    test_random_traffic();
    start <= 1'b0;
    waited = 0;
    while (expected_sums.size() != 0 && waited < 100 * BEAT_LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (BEAT_LATENCY) @(posedge clk);
    if (expected_sums.size() != 0) begin
      $error("%0d result beats never arrived", expected_sums.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("peak_live_waste_tracker test passed");
    end else begin
      $display("peak_live_waste_tracker test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/plwt_pkg.sv
rtl/core/plwt_cell.sv
rtl/core/peak_live_waste_tracker.sv
tb/tb_peak_live_waste_tracker.sv
